// ===== rtl/core/crcfv_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crcfv_pkg
// Constants, status codes and the bytewise CRC-32 step for the frame validator.
// ----------------------------------------------------------------------------
package crcfv_pkg;

    localparam int unsigned FRAME_BYTES_DEF   = 1024;
    localparam int unsigned PAYLOAD_BYTES_DEF = 1008;
    localparam int unsigned PAYLOAD_START     = 9;
    localparam int unsigned CHANNEL_POS       = 4;
    localparam int unsigned COUNTER_FIRST     = 5;
    localparam int unsigned COUNTER_LAST      = 7;
    localparam int unsigned HEAD_SPACER_POS   = 8;

    localparam logic [31:0] CRC_POLY     = 32'hEDB8_8320;
    localparam logic [31:0] CRC_ALL_ONES = 32'hFFFF_FFFF;
    localparam logic [7:0]  SPACER_FF    = 8'hFF;
    localparam logic [7:0]  SPACER_EF    = 8'hEF;

    localparam logic [7:0]  WANTED_CHANNEL_RESET = 8'h41;

    // register index, taken from paddr[2]
    localparam logic        REG_WANTED_CHANNEL = 1'b0;

    typedef enum logic [1:0] {
        ST_GOOD       = 2'd0,
        ST_CRC_ERR    = 2'd1,
        ST_SPACER_ERR = 2'd2
    } t_frame_status;

    // reflected crc-32, one byte, lsb first
    function automatic logic [31:0] crc_byte(input logic [31:0] crc_in,
                                             input logic [7:0]  data);
        logic [31:0] crc;
        crc = crc_in ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
        end
        return crc;
    endfunction

endpackage

// ===== rtl/core/crc32_frame_validator_top.sv =====
// ----------------------------------------------------------------------------
// crc32_frame_validator_top
// Takes one frame byte per cycle unless stalled: payload bytes come out as
// they arrive, and the last byte of each frame yields one verdict item (CRC
// first, then the spacers) with channel, counter and file-start flags. An
// accepted byte sits in the input register, where a bytewise CRC step and the
// verdict logic update state, and its result lands in the output register.
// The input side stalls only when the staged byte yields an item and the
// output register still holds one that is stalled. A payload byte that is
// discarded downstream is recognized by a non-good verdict at frame end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module crc32_frame_validator_top
    import crcfv_pkg::*;
#(
    parameter int unsigned FRAME_BYTES   = FRAME_BYTES_DEF,
    parameter int unsigned PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,

    // input channel
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_data_byte,

    // output channel
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic        o_result_kind,
    output logic [7:0]  o_payload_byte,
    output logic [1:0]  o_frame_status,
    output logic [7:0]  o_channel_id,
    output logic [23:0] o_frame_counter,
    output logic        o_channel_match,
    output logic        o_starts_new_file,
    output logic        o_previous_file_kept
);

    localparam int unsigned PW          = $clog2(FRAME_BYTES);
    localparam int unsigned LAST_POS    = FRAME_BYTES - 1;
    localparam int unsigned PAYLOAD_END = PAYLOAD_START + PAYLOAD_BYTES;
    localparam int unsigned TAIL_SPACER = FRAME_BYTES - 7;
    localparam int unsigned RXCRC_FIRST = FRAME_BYTES - 6;
    localparam int unsigned RXCRC_LAST  = FRAME_BYTES - 3;
    localparam int unsigned END_SPACER  = FRAME_BYTES - 2;

    // configuration register
    logic [7:0] r_wanted;
    logic       cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wanted <= WANTED_CHANNEL_RESET;
        end else if (cfg_wr && (paddr[2] == REG_WANTED_CHANNEL)) begin
            r_wanted <= pwdata[7:0];
        end
    end

    assign prdata = (paddr[2] == REG_WANTED_CHANNEL) ? {24'd0, r_wanted} : 32'd0;

    // input register
    logic       r_in_valid;
    logic [7:0] r_in_byte;

    // frame state
    logic [PW-1:0] r_pos;
    logic [31:0]   r_crc;
    logic [7:0]    r_channel;
    logic [23:0]   r_counter;
    logic [31:0]   r_rx_crc;
    logic          r_spacers_ok;
    logic [1:0]    r_frames;

    // output register
    logic          r_out_valid;
    logic          r_kind;
    logic [7:0]    r_payload;
    t_frame_status r_status;
    logic [7:0]    r_chan_out;
    logic [23:0]   r_cnt_out;
    logic          r_match;
    logic          r_starts;
    logic          r_kept;

    // next values
    logic [PW-1:0] n_pos;
    logic [31:0]   n_crc;
    logic [7:0]    n_channel;
    logic [23:0]   n_counter;
    logic [31:0]   n_rx_crc;
    logic          n_spacers_ok;
    logic [1:0]    n_frames;
    t_frame_status n_status;
    logic          n_match;
    logic          n_starts;
    logic          n_kept;

    logic [31:0] pos32;
    logic        is_last;
    logic        is_payload;
    logic        produces;
    logic        out_free;
    logic        advance;
    logic        in_accept;

    assign pos32      = 32'(r_pos);
    assign is_last    = (pos32 >= LAST_POS);
    assign is_payload = (pos32 >= PAYLOAD_START) && (pos32 < PAYLOAD_END);
    assign produces   = is_last || is_payload;
    assign out_free   = !r_out_valid || !i_out_stall;
    assign advance    = r_in_valid && (!produces || out_free);
    assign o_in_stall = r_in_valid && !advance;
    assign in_accept  = i_in_valid && !o_in_stall;

    always_comb begin
        n_channel    = (pos32 == CHANNEL_POS) ? r_in_byte : r_channel;
        n_counter    = ((pos32 >= COUNTER_FIRST) && (pos32 <= COUNTER_LAST)) ?
                       {r_counter[15:0], r_in_byte} : r_counter;
        n_crc        = is_payload ? crc_byte(r_crc, r_in_byte) : r_crc;
        n_rx_crc     = ((pos32 >= RXCRC_FIRST) && (pos32 <= RXCRC_LAST)) ?
                       {r_rx_crc[23:0], r_in_byte} : r_rx_crc;
        n_spacers_ok = r_spacers_ok;
        if ((pos32 == HEAD_SPACER_POS) && (r_in_byte != SPACER_FF)) begin
            n_spacers_ok = 1'b0;
        end
        if ((pos32 == TAIL_SPACER) && (r_in_byte != SPACER_EF)) begin
            n_spacers_ok = 1'b0;
        end
        if ((pos32 >= END_SPACER) && (r_in_byte != SPACER_FF)) begin
            n_spacers_ok = 1'b0;
        end

        if ((n_crc ^ CRC_ALL_ONES) != n_rx_crc) begin
            n_status = ST_CRC_ERR;
        end else if (!n_spacers_ok) begin
            n_status = ST_SPACER_ERR;
        end else begin
            n_status = ST_GOOD;
        end

        n_match  = (n_channel == r_wanted);
        n_starts = 1'b0;
        n_kept   = 1'b0;
        n_frames = r_frames;
        if ((n_status == ST_GOOD) && n_match) begin
            if (n_counter == 24'd0) begin
                n_starts = 1'b1;
                n_kept   = (r_frames >= 2'd2);
                n_frames = 2'd1;
            end else if (r_frames != 2'd3) begin
                n_frames = r_frames + 2'd1;
            end
        end

        n_pos = is_last ? '0 : r_pos + 1'b1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_pos        <= '0;
            r_crc        <= CRC_ALL_ONES;
            r_channel    <= 8'd0;
            r_counter    <= 24'd0;
            r_rx_crc     <= 32'd0;
            r_spacers_ok <= 1'b1;
            r_frames     <= 2'd0;
            r_out_valid  <= 1'b0;
        end else begin
            if (in_accept) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_pos     <= n_pos;
                r_channel <= n_channel;
                r_counter <= n_counter;
                r_rx_crc  <= n_rx_crc;
                if (is_last) begin
                    r_crc        <= CRC_ALL_ONES;
                    r_spacers_ok <= 1'b1;
                    r_frames     <= n_frames;
                end else begin
                    r_crc        <= n_crc;
                    r_spacers_ok <= n_spacers_ok;
                end
            end

            if (advance && produces) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers, no reset
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_byte <= i_data_byte;
        end
        if (advance && produces) begin
            // the verdict wins over a payload byte at the last offset
            if (is_last) begin
                r_kind     <= 1'b1;
                r_payload  <= 8'd0;
                r_status   <= n_status;
                r_chan_out <= n_channel;
                r_cnt_out  <= n_counter;
                r_match    <= n_match;
                r_starts   <= n_starts;
                r_kept     <= n_kept;
            end else begin
                r_kind     <= 1'b0;
                r_payload  <= r_in_byte;
                r_status   <= ST_GOOD;
                r_chan_out <= 8'd0;
                r_cnt_out  <= 24'd0;
                r_match    <= 1'b0;
                r_starts   <= 1'b0;
                r_kept     <= 1'b0;
            end
        end
    end

    assign o_out_valid          = r_out_valid;
    assign o_result_kind        = r_kind;
    assign o_payload_byte       = r_payload;
    assign o_frame_status       = r_status;
    assign o_channel_id         = r_chan_out;
    assign o_frame_counter      = r_cnt_out;
    assign o_channel_match      = r_match;
    assign o_starts_new_file    = r_starts;
    assign o_previous_file_kept = r_kept;

    // checks
    a_pos_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pos32 <= LAST_POS)
        else $error("byte position ran past frame end");

    a_frame_restart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && is_last |=> (r_pos == '0) && (r_crc == CRC_ALL_ONES) && r_spacers_ok)
        else $error("frame state not restarted after verdict");

    a_start_is_good: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_starts |->
            r_kind && (r_status == ST_GOOD) && r_match && (r_cnt_out == 24'd0))
        else $error("file start on a frame that does not qualify");

    a_kept_needs_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_kept |-> r_starts)
        else $error("previous file kept without a new start");

    a_no_silent_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && i_out_stall |=> r_out_valid)
        else $error("stalled item dropped");

endmodule

// ===== bench/crc32_frame_validator_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// crc32_frame_validator_top_tb
// Self-checking bench for the frame validator. One whole clean frame that
// starts a file on the wanted channel is streamed in while the output side
// holds off for a long stretch, then the register is changed and read back
// over the APB port and the head of one more frame follows. Both sides idle
// at random. Every accepted byte goes through a tracker that predicts payload
// items and end-of-frame verdicts; each output item is compared with the
// oldest prediction.
// ----------------------------------------------------------------------------

module crc32_frame_validator_top_tb;

    import crcfv_pkg::*;

    localparam int unsigned FRAME_LEN   = FRAME_BYTES_DEF;
    localparam int unsigned PAYLOAD_LEN = PAYLOAD_BYTES_DEF;
    localparam int unsigned TAIL_BYTES  = 126;
    localparam int unsigned CYCLE_LIMIT = 400_000;
    localparam int unsigned HOLD_CYCLES = 300;
    localparam int unsigned MAX_IDLE    = 17;

    localparam logic [2:0] ADDR_WANTED = {REG_WANTED_CHANNEL, 2'b00};
    localparam logic [2:0] ADDR_SPARE  = {~REG_WANTED_CHANNEL, 2'b00};

    typedef enum int unsigned {
        FR_CLEAN,
        FR_BAD_CRC,
        FR_BAD_SPACER,
        FR_BAD_BOTH
    } t_frame_fault;

    typedef struct packed {
        logic          kind;
        logic [7:0]    payload;
        t_frame_status status;
        logic [7:0]    chan;
        logic [23:0]   counter;
        logic          match;
        logic          starts;
        logic          kept;
    } t_frame_item;

    class frame_tracker;
        int unsigned   pos;
        logic [31:0]   crc_acc;
        logic [7:0]    chan;
        logic [23:0]   counter;
        logic [31:0]   fcs_rx;
        bit            spacers_ok;
        logic [1:0]    file_frames;
        logic [7:0]    wanted;
        t_frame_item   due_items[$];
        int unsigned   errors;

        function new();
            pos         = 0;
            crc_acc     = CRC_ALL_ONES;
            chan        = '0;
            counter     = '0;
            fcs_rx      = '0;
            spacers_ok  = 1'b1;
            file_frames = '0;
            wanted      = WANTED_CHANNEL_RESET;
            errors      = 0;
        endfunction

        // reflected crc-32, one data bit per step
        function logic [31:0] crc_fold(logic [31:0] c, logic [7:0] b);
            logic fb;
            for (int i = 0; i < 8; i++) begin
                fb = c[0] ^ b[i];
                c  = c >> 1;
                if (fb) begin
                    c = c ^ CRC_POLY;
                end
            end
            return c;
        endfunction

        function void note_config(logic idx, logic [31:0] value);
            if (idx == REG_WANTED_CHANNEL) begin
                wanted = value[7:0];
            end
        endfunction

        function int unsigned outstanding();
            return due_items.size();
        endfunction

        function void take_byte(logic [7:0] b);
            int unsigned at;
            bit          in_payload;
            t_frame_item r;
            at         = pos;
            in_payload = (at >= PAYLOAD_START) && (at < PAYLOAD_START + PAYLOAD_LEN);
            r          = '0;
            if (at == CHANNEL_POS) begin
                chan = b;
            end
            if (at >= COUNTER_FIRST && at <= COUNTER_LAST) begin
                counter = {counter[15:0], b};
            end
            if (at == HEAD_SPACER_POS && b != SPACER_FF) begin
                spacers_ok = 1'b0;
            end
            if (in_payload) begin
                crc_acc = crc_fold(crc_acc, b);
            end
            if (at == FRAME_LEN - 7 && b != SPACER_EF) begin
                spacers_ok = 1'b0;
            end
            if (at >= FRAME_LEN - 6 && at <= FRAME_LEN - 3) begin
                fcs_rx = {fcs_rx[23:0], b};
            end
            if (at >= FRAME_LEN - 2 && b != SPACER_FF) begin
                spacers_ok = 1'b0;
            end
            if (at >= FRAME_LEN - 1) begin
                r.kind    = 1'b1;
                r.chan    = chan;
                r.counter = counter;
                r.match   = (chan == wanted);
                if ((crc_acc ^ CRC_ALL_ONES) != fcs_rx) begin
                    r.status = ST_CRC_ERR;
                end else if (!spacers_ok) begin
                    r.status = ST_SPACER_ERR;
                end else begin
                    r.status = ST_GOOD;
                end
                // only good frames on the wanted channel move the file count
                if (r.status == ST_GOOD && r.match) begin
                    if (counter == 24'd0) begin
                        r.starts    = 1'b1;
                        r.kept      = (file_frames >= 2'd2);
                        file_frames = 2'd1;
                    end else if (file_frames != 2'd3) begin
                        file_frames = file_frames + 2'd1;
                    end
                end
                due_items.push_back(r);
                pos        = 0;
                crc_acc    = CRC_ALL_ONES;
                spacers_ok = 1'b1;
            end else begin
                pos = at + 1;
                if (in_payload) begin
                    r.payload = b;
                    due_items.push_back(r);
                end
            end
        endfunction

        task flag_mismatch(string msg);
            errors++;
            $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        task match_item(t_frame_item got);
            t_frame_item want;
            string       diffs;
            diffs = "";
            if (due_items.size() == 0) begin
                flag_mismatch($sformatf("item with nothing pending, kind=%0d", got.kind));
                return;
            end
            want = due_items.pop_front();
            if (got.kind !== want.kind)
                diffs = {diffs, $sformatf(" kind %0d/%0d", got.kind, want.kind)};
            if (got.payload !== want.payload)
                diffs = {diffs, $sformatf(" byte %h/%h", got.payload, want.payload)};
            if (got.status !== want.status)
                diffs = {diffs, $sformatf(" verdict %0d/%0d", got.status, want.status)};
            if (got.chan !== want.chan)
                diffs = {diffs, $sformatf(" chan %h/%h", got.chan, want.chan)};
            if (got.counter !== want.counter)
                diffs = {diffs, $sformatf(" cnt %h/%h", got.counter, want.counter)};
            if (got.match !== want.match)
                diffs = {diffs, $sformatf(" match %0d/%0d", got.match, want.match)};
            if (got.starts !== want.starts)
                diffs = {diffs, $sformatf(" start %0d/%0d", got.starts, want.starts)};
            if (got.kept !== want.kept)
                diffs = {diffs, $sformatf(" kept %0d/%0d", got.kept, want.kept)};
            if (diffs != "") begin
                flag_mismatch({"item (got/exp):", diffs});
            end
        endtask
    endclass

    logic        i_clk;
    logic        i_rst_n       = 1'b0;
    logic        psel          = 1'b0;
    logic        penable       = 1'b0;
    logic        pwrite        = 1'b0;
    logic [2:0]  paddr         = '0;
    logic [31:0] pwdata        = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid    = 1'b0;
    logic        o_in_stall;
    logic [7:0]  i_data_byte   = '0;
    logic        o_out_valid;
    logic        i_out_stall   = 1'b0;
    logic        o_result_kind;
    logic [7:0]  o_payload_byte;
    logic [1:0]  o_frame_status;
    logic [7:0]  o_channel_id;
    logic [23:0] o_frame_counter;
    logic        o_channel_match;
    logic        o_starts_new_file;
    logic        o_previous_file_kept;

    frame_tracker tracker;
    t_frame_item  seen;
    logic [7:0]   cur_wanted  = WANTED_CHANNEL_RESET;
    bit           rx_hold_req = 1'b0;
    int unsigned  sent_count  = 0;
    int unsigned  cycle_count = 0;

    crc32_frame_validator_top #(
        .FRAME_BYTES   (FRAME_LEN),
        .PAYLOAD_BYTES (PAYLOAD_LEN)
    ) dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .prdata               (prdata),
        .pready               (pready),
        .i_in_valid           (i_in_valid),
        .o_in_stall           (o_in_stall),
        .i_data_byte          (i_data_byte),
        .o_out_valid          (o_out_valid),
        .i_out_stall          (i_out_stall),
        .o_result_kind        (o_result_kind),
        .o_payload_byte       (o_payload_byte),
        .o_frame_status       (o_frame_status),
        .o_channel_id         (o_channel_id),
        .o_frame_counter      (o_frame_counter),
        .o_channel_match      (o_channel_match),
        .o_starts_new_file    (o_starts_new_file),
        .o_previous_file_kept (o_previous_file_kept)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                tracker.take_byte(i_data_byte);
            end
            if (o_out_valid && !i_out_stall) begin
                seen.kind    = o_result_kind;
                seen.payload = o_payload_byte;
                seen.status  = t_frame_status'(o_frame_status);
                seen.chan    = o_channel_id;
                seen.counter = o_frame_counter;
                seen.match   = o_channel_match;
                seen.starts  = o_starts_new_file;
                seen.kept    = o_previous_file_kept;
                tracker.match_item(seen);
            end
        end
    end

    // output side: random hold-off per item, or one long hold on request
    initial begin
        int unsigned hold;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                hold        = HOLD_CYCLES;
            end else begin
                hold = $urandom_range(0, MAX_IDLE);
            end
            if (hold != 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!(o_out_valid && !i_out_stall));
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        tracker.note_config(addr[2], data);
    endtask

    task automatic readback_wanted();
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_WANTED;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        if (prdata[7:0] !== tracker.wanted) begin
            tracker.flag_mismatch($sformatf("wanted channel reads %h, exp %h",
                                            prdata[7:0], tracker.wanted));
        end
    endtask

    task automatic set_wanted(input logic [7:0] v);
        // junk in the upper bits must not reach the register
        apb_write(ADDR_WANTED, ($urandom() & 32'hFFFF_FF00) | {24'd0, v});
        cur_wanted = v;
        readback_wanted();
    endtask

    task automatic send_byte(input logic [7:0] b);
        int unsigned gap;
        gap = $urandom_range(0, MAX_IDLE);
        if (gap != 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_in_stall);
        sent_count++;
    endtask

    // drop valid and let the block run dry before touching the register
    task automatic pause_sending();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (tracker.outstanding() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic send_frame(input logic [7:0] chan, input logic [23:0] cnt,
                              input t_frame_fault fault, input int unsigned cut,
                              input bit directed);
        logic [7:0]  body [FRAME_LEN];
        logic [31:0] fcs;
        int unsigned spot;
        fcs = CRC_ALL_ONES;
        for (int i = 0; i < FRAME_LEN; i++) begin
            body[i] = directed ? ((i % 2) ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
        end
        body[CHANNEL_POS]       = chan;
        body[COUNTER_FIRST]     = cnt[23:16];
        body[COUNTER_FIRST + 1] = cnt[15:8];
        body[COUNTER_LAST]      = cnt[7:0];
        body[HEAD_SPACER_POS]   = SPACER_FF;
        for (int i = PAYLOAD_START; i < PAYLOAD_START + PAYLOAD_LEN; i++) begin
            fcs = tracker.crc_fold(fcs, body[i]);
        end
        fcs = fcs ^ CRC_ALL_ONES;
        if (fault == FR_BAD_CRC || fault == FR_BAD_BOTH) begin
            fcs = fcs ^ ($urandom() | 32'h1);
        end
        body[FRAME_LEN - 7] = SPACER_EF;
        body[FRAME_LEN - 6] = fcs[31:24];
        body[FRAME_LEN - 5] = fcs[23:16];
        body[FRAME_LEN - 4] = fcs[15:8];
        body[FRAME_LEN - 3] = fcs[7:0];
        body[FRAME_LEN - 2] = SPACER_FF;
        body[FRAME_LEN - 1] = SPACER_FF;
        if (fault == FR_BAD_SPACER || fault == FR_BAD_BOTH) begin
            case ($urandom_range(0, 3))
                0: begin
                    spot = HEAD_SPACER_POS;
                end
                1: begin
                    spot = FRAME_LEN - 7;
                end
                2: begin
                    spot = FRAME_LEN - 2;
                end
                default: begin
                    spot = FRAME_LEN - 1;
                end
            endcase
            body[spot] = body[spot] ^ 8'($urandom_range(1, 255));
        end
        for (int i = 0; i < cut; i++) begin
            send_byte(body[i]);
        end
    endtask

    function automatic logic [23:0] random_counter();
        case ($urandom_range(0, 3))
            0: return 24'd0;
            1: return 24'hFF_FFFF;
            default: return 24'($urandom());
        endcase
    endfunction

    function automatic logic [7:0] random_channel();
        case ($urandom_range(0, 4))
            0: return 8'h00;
            1: return 8'hFF;
            2: return cur_wanted;
            3: return cur_wanted ^ 8'h01;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    initial begin
        tracker = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset value of the wanted channel, then a clean file start on it
        // while the output side holds off once for a long stretch
        readback_wanted();
        rx_hold_req = 1'b1;
        send_frame(cur_wanted, 24'd0, FR_CLEAN, FRAME_LEN, 1'b1);
        pause_sending();

        // write to the unused slot must leave the register alone
        apb_write(ADDR_SPARE, $urandom());
        readback_wanted();
        set_wanted(8'($urandom_range(0, 255)));

        // header and the first part of the payload of one more frame
        send_frame(random_channel(), random_counter(), FR_CLEAN, TAIL_BYTES, 1'b0);
        pause_sending();

        if (tracker.errors == 0 && tracker.outstanding() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
